/* rtl/core/phong_pkg.sv */
package phong_pkg;

    // field widths of the pixel and color items
    localparam int VEC_W     = 16;
    localparam int CH_W      = 16;
    localparam int NUM_CH    = 3;
    localparam int RGB_W     = NUM_CH * CH_W;
    localparam int SHINE_W   = 6;
    localparam int COLOR_W   = 8;

    localparam logic [COLOR_W-1:0] COLOR_MAX = '1;

    // per-channel light scale products carried down the pipeline
    localparam int NUM_SC  = 3;
    localparam int SC_DIFF = 0;
    localparam int SC_SPEC = 1;
    localparam int SC_AMB  = 2;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LIGHT   = 1'b0,
        CFG_AMBIENT = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic signed [VEC_W-1:0] dir_x;
        logic signed [VEC_W-1:0] dir_y;
        logic signed [VEC_W-1:0] dir_z;
        logic signed [VEC_W-1:0] light_dir_x;
        logic signed [VEC_W-1:0] light_dir_y;
        logic signed [VEC_W-1:0] light_dir_z;
        logic signed [VEC_W-1:0] normal_x;
        logic signed [VEC_W-1:0] normal_y;
        logic signed [VEC_W-1:0] normal_z;
        logic [RGB_W-1:0]        diffuse_rgb;
        logic [RGB_W-1:0]        specular_rgb;
        logic [SHINE_W-1:0]      shininess;
    } pixel_t;

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } color_t;

endpackage

/* rtl/core/phong_front.sv */
module phong_front #(
    parameter int FRAC_BITS = 15,
    parameter int M_W       = 6
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         pix_valid,
    input  phong_pkg::pixel_t            pix,
    input  logic [phong_pkg::RGB_W-1:0]  light,
    input  logic [phong_pkg::RGB_W-1:0]  ambient,
    output logic                         vec_valid,
    output logic [FRAC_BITS:0]           ld,
    output logic [FRAC_BITS:0]           rs,
    output logic [FRAC_BITS:0]           p0,
    output logic [M_W-1:0]               shine,
    output logic [phong_pkg::NUM_CH*phong_pkg::NUM_SC*(2*phong_pkg::CH_W-FRAC_BITS)-1:0] scale
);
    import phong_pkg::*;

    localparam int U_W    = FRAC_BITS + 1;
    localparam int S_W    = 2 * CH_W - FRAC_BITS;
    localparam int SC_W   = NUM_CH * NUM_SC * S_W;
    localparam int PROD_W = 2 * VEC_W;
    localparam int DOT_W  = PROD_W + 1;
    localparam int LN_W   = DOT_W - FRAC_BITS;
    localparam int PR_W   = LN_W + VEC_W;
    localparam int RS1_W  = PR_W - FRAC_BITS + 1;
    localparam int R_W    = ((RS1_W > VEC_W) ? RS1_W : VEC_W) + 1;
    localparam int ND_W   = VEC_W + 1;
    localparam int Q_W    = R_W + ND_W;
    localparam int RX_W   = Q_W + 2;
    localparam int RXS_W  = RX_W - FRAC_BITS;
    localparam int LNX_W  = (LN_W > U_W + 1) ? LN_W : U_W + 1;
    localparam int RXX_W  = (RXS_W > U_W + 1) ? RXS_W : U_W + 1;

    localparam logic [U_W-1:0]          ONE     = U_W'(1) << FRAC_BITS;
    localparam logic signed [LNX_W-1:0] ONE_LNX = LNX_W'(1) << FRAC_BITS;
    localparam logic signed [RXX_W-1:0] ONE_RXX = RXX_W'(1) << FRAC_BITS;

    // input views
    logic signed [VEC_W-1:0] d_in [NUM_CH];
    logic signed [VEC_W-1:0] l_in [NUM_CH];
    logic signed [VEC_W-1:0] n_in [NUM_CH];
    logic [CH_W-1:0]         kd_in [NUM_CH];
    logic [CH_W-1:0]         ke_in [NUM_CH];
    logic [CH_W-1:0]         lt_in [NUM_CH];
    logic [CH_W-1:0]         am_in [NUM_CH];
    logic                    shadow_in;
    logic [2*CH_W-1:0]       sc_full [NUM_CH][NUM_SC];
    logic [SC_W-1:0]         scale_next;

    // stage 1: l.n partial products, light scale products
    logic                     s1_valid_reg;
    logic signed [PROD_W-1:0] s1_prod_reg [NUM_CH];
    logic signed [VEC_W-1:0]  s1_l_reg [NUM_CH];
    logic signed [VEC_W-1:0]  s1_n_reg [NUM_CH];
    logic signed [VEC_W-1:0]  s1_d_reg [NUM_CH];
    logic [M_W-1:0]           s1_shine_reg;
    logic                     s1_shadow_reg;
    logic [SC_W-1:0]          s1_scale_reg;

    // stage 2: l.n
    logic                     s2_valid_reg;
    logic signed [LN_W-1:0]   s2_ln_reg;
    logic signed [VEC_W-1:0]  s2_l_reg [NUM_CH];
    logic signed [VEC_W-1:0]  s2_n_reg [NUM_CH];
    logic signed [VEC_W-1:0]  s2_d_reg [NUM_CH];
    logic [M_W-1:0]           s2_shine_reg;
    logic                     s2_shadow_reg;
    logic [SC_W-1:0]          s2_scale_reg;

    // stage 3: (l.n) n products, clamped diffuse factor
    logic                     s3_valid_reg;
    logic signed [PR_W-1:0]   s3_pr_reg [NUM_CH];
    logic signed [VEC_W-1:0]  s3_l_reg [NUM_CH];
    logic signed [VEC_W-1:0]  s3_d_reg [NUM_CH];
    logic [U_W-1:0]           s3_ld_reg;
    logic [M_W-1:0]           s3_shine_reg;
    logic                     s3_shadow_reg;
    logic [SC_W-1:0]          s3_scale_reg;

    // stage 4: reflection vector
    logic                     s4_valid_reg;
    logic signed [R_W-1:0]    s4_r_reg [NUM_CH];
    logic signed [VEC_W-1:0]  s4_d_reg [NUM_CH];
    logic [U_W-1:0]           s4_ld_reg;
    logic [M_W-1:0]           s4_shine_reg;
    logic                     s4_shadow_reg;
    logic [SC_W-1:0]          s4_scale_reg;

    // stage 5: r.(-dir) partial products
    logic                     s5_valid_reg;
    logic signed [Q_W-1:0]    s5_q_reg [NUM_CH];
    logic [U_W-1:0]           s5_ld_reg;
    logic [M_W-1:0]           s5_shine_reg;
    logic                     s5_shadow_reg;
    logic [SC_W-1:0]          s5_scale_reg;

    // stage 6: clamped factors
    logic                     s6_valid_reg;
    logic [U_W-1:0]           s6_ld_reg;
    logic [U_W-1:0]           s6_rs_reg;
    logic [U_W-1:0]           s6_p0_reg;
    logic [M_W-1:0]           s6_shine_reg;
    logic [SC_W-1:0]          s6_scale_reg;

    logic signed [DOT_W-1:0]  dot_next;
    logic signed [LN_W-1:0]   ln_next;
    logic signed [LNX_W-1:0]  ln_x;
    logic [U_W-1:0]           ld_next;
    logic signed [R_W-1:0]    r_next [NUM_CH];
    logic signed [ND_W-1:0]   nd [NUM_CH];
    logic signed [RX_W-1:0]   rx_sum;
    logic signed [RXX_W-1:0]  rx_x;
    logic [U_W-1:0]           rs_next;

    always_comb
    begin
        d_in[0] = pix.dir_x;
        d_in[1] = pix.dir_y;
        d_in[2] = pix.dir_z;
        l_in[0] = pix.light_dir_x;
        l_in[1] = pix.light_dir_y;
        l_in[2] = pix.light_dir_z;
        n_in[0] = pix.normal_x;
        n_in[1] = pix.normal_y;
        n_in[2] = pix.normal_z;
        shadow_in = (pix.light_dir_x == '0) && (pix.light_dir_y == '0)
                    && (pix.light_dir_z == '0);
        scale_next = '0;
        for (int c = 0; c < NUM_CH; c++)
        begin
            kd_in[c] = pix.diffuse_rgb[c*CH_W +: CH_W];
            ke_in[c] = pix.specular_rgb[c*CH_W +: CH_W];
            lt_in[c] = light[c*CH_W +: CH_W];
            am_in[c] = ambient[c*CH_W +: CH_W];
            sc_full[c][SC_DIFF] = lt_in[c] * kd_in[c];
            sc_full[c][SC_SPEC] = lt_in[c] * ke_in[c];
            sc_full[c][SC_AMB]  = am_in[c] * kd_in[c];
            for (int k = 0; k < NUM_SC; k++)
            begin
                scale_next[(c*NUM_SC+k)*S_W +: S_W] = S_W'(sc_full[c][k] >> FRAC_BITS);
            end
        end
    end

    // l.n, floor-shifted
    always_comb
    begin
        dot_next = DOT_W'(s1_prod_reg[0]) + DOT_W'(s1_prod_reg[1])
                   + DOT_W'(s1_prod_reg[2]);
        ln_next  = LN_W'(dot_next >>> FRAC_BITS);
    end

    // diffuse factor clamped to [0, 1]
    always_comb
    begin
        ln_x = LNX_W'(s2_ln_reg);
        if (ln_x[LNX_W-1])
        begin
            ld_next = '0;
        end
        else if (ln_x > ONE_LNX)
        begin
            ld_next = ONE;
        end
        else
        begin
            ld_next = U_W'(ln_x);
        end
    end

    // r = 2(l.n)n - l, negated view direction
    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            r_next[c] = R_W'(s3_pr_reg[c] >>> (FRAC_BITS - 1)) - R_W'(s3_l_reg[c]);
            nd[c]     = -ND_W'(s4_d_reg[c]);
        end
    end

    // specular base clamped to [0, 1]
    always_comb
    begin
        rx_sum = RX_W'(s5_q_reg[0]) + RX_W'(s5_q_reg[1]) + RX_W'(s5_q_reg[2]);
        rx_x   = RXX_W'(rx_sum >>> FRAC_BITS);
        if (rx_x[RXX_W-1])
        begin
            rs_next = '0;
        end
        else if (rx_x > ONE_RXX)
        begin
            rs_next = ONE;
        end
        else
        begin
            rs_next = U_W'(rx_x);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= pix_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
            s6_valid_reg <= s5_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < NUM_CH; c++)
            begin
                s1_prod_reg[c] <= l_in[c] * n_in[c];
                s1_l_reg[c]    <= l_in[c];
                s1_n_reg[c]    <= n_in[c];
                s1_d_reg[c]    <= d_in[c];
                s2_l_reg[c]    <= s1_l_reg[c];
                s2_n_reg[c]    <= s1_n_reg[c];
                s2_d_reg[c]    <= s1_d_reg[c];
                s3_pr_reg[c]   <= PR_W'(s2_ln_reg) * PR_W'(s2_n_reg[c]);
                s3_l_reg[c]    <= s2_l_reg[c];
                s3_d_reg[c]    <= s2_d_reg[c];
                s4_r_reg[c]    <= r_next[c];
                s4_d_reg[c]    <= s3_d_reg[c];
                s5_q_reg[c]    <= Q_W'(s4_r_reg[c]) * Q_W'(nd[c]);
            end
            s1_shine_reg  <= pix.shininess[M_W-1:0];
            s1_shadow_reg <= shadow_in;
            s1_scale_reg  <= scale_next;

            s2_ln_reg     <= ln_next;
            s2_shine_reg  <= s1_shine_reg;
            s2_shadow_reg <= s1_shadow_reg;
            s2_scale_reg  <= s1_scale_reg;

            s3_ld_reg     <= ld_next;
            s3_shine_reg  <= s2_shine_reg;
            s3_shadow_reg <= s2_shadow_reg;
            s3_scale_reg  <= s2_scale_reg;

            s4_ld_reg     <= s3_ld_reg;
            s4_shine_reg  <= s3_shine_reg;
            s4_shadow_reg <= s3_shadow_reg;
            s4_scale_reg  <= s3_scale_reg;

            s5_ld_reg     <= s4_ld_reg;
            s5_shine_reg  <= s4_shine_reg;
            s5_shadow_reg <= s4_shadow_reg;
            s5_scale_reg  <= s4_scale_reg;

            // shadow: no diffuse, and a zero starting power term that stays zero for every m
            s6_ld_reg     <= s5_shadow_reg ? '0 : s5_ld_reg;
            s6_rs_reg     <= rs_next;
            s6_p0_reg     <= s5_shadow_reg ? '0 : ONE;
            s6_shine_reg  <= s5_shine_reg;
            s6_scale_reg  <= s5_scale_reg;
        end
    end

    assign vec_valid = s6_valid_reg;
    assign ld        = s6_ld_reg;
    assign rs        = s6_rs_reg;
    assign p0        = s6_p0_reg;
    assign shine     = s6_shine_reg;
    assign scale     = s6_scale_reg;

endmodule

/* rtl/core/phong_pow.sv */
module phong_pow #(
    parameter int FRAC_BITS = 15,
    parameter int M_W       = 6,
    parameter int SIDE_W    = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              head_valid,
    input  logic [FRAC_BITS:0] head_rs,
    input  logic [FRAC_BITS:0] head_p,
    input  logic [M_W-1:0]    head_shine,
    input  logic [SIDE_W-1:0] head_side,
    output logic              tail_valid,
    output logic [FRAC_BITS:0] tail_p,
    output logic [SIDE_W-1:0] tail_side
);
    import phong_pkg::*;

    localparam int U_W   = FRAC_BITS + 1;
    localparam int NSTEP = (1 << M_W) - 1;

    localparam logic [U_W-1:0] ONE = U_W'(1) << FRAC_BITS;

    // one exponent step per stage; stage k multiplies when k < m
    logic              valid_reg [NSTEP];
    logic [U_W-1:0]    p_reg     [NSTEP];
    logic [U_W-1:0]    rs_reg    [NSTEP];
    logic [M_W-1:0]    shine_reg [NSTEP];
    logic [SIDE_W-1:0] side_reg  [NSTEP];

    logic              v_in     [NSTEP];
    logic [U_W-1:0]    p_in     [NSTEP];
    logic [U_W-1:0]    rs_in    [NSTEP];
    logic [M_W-1:0]    shine_in [NSTEP];
    logic [SIDE_W-1:0] side_in  [NSTEP];
    logic [2*U_W-1:0]  prod     [NSTEP];
    logic [U_W-1:0]    p_next   [NSTEP];

    assign v_in[0]     = head_valid;
    assign p_in[0]     = head_p;
    assign rs_in[0]    = head_rs;
    assign shine_in[0] = head_shine;
    assign side_in[0]  = head_side;

    for (genvar k = 1; k < NSTEP; k++)
    begin : g_link
        assign v_in[k]     = valid_reg[k-1];
        assign p_in[k]     = p_reg[k-1];
        assign rs_in[k]    = rs_reg[k-1];
        assign shine_in[k] = shine_reg[k-1];
        assign side_in[k]  = side_reg[k-1];
    end

    always_comb
    begin
        for (int k = 0; k < NSTEP; k++)
        begin
            prod[k]   = (2*U_W)'(p_in[k]) * (2*U_W)'(rs_in[k]);
            p_next[k] = (shine_in[k] > M_W'(k)) ? U_W'(prod[k] >> FRAC_BITS) : p_in[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NSTEP; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            for (int k = 0; k < NSTEP; k++)
            begin
                valid_reg[k] <= v_in[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < NSTEP; k++)
            begin
                p_reg[k]     <= p_next[k];
                rs_reg[k]    <= rs_in[k];
                shine_reg[k] <= shine_in[k];
                side_reg[k]  <= side_in[k];
            end
        end
    end

    assign tail_valid = valid_reg[NSTEP-1];
    assign tail_p     = p_reg[NSTEP-1];
    assign tail_side  = side_reg[NSTEP-1];

    a_pow_unit: assert property (@(posedge clk) disable iff (!rst_n)
        tail_valid |-> tail_p <= ONE)
        else $error("power term above one");

    a_base_unit: assert property (@(posedge clk) disable iff (!rst_n)
        tail_valid |-> rs_reg[NSTEP-1] <= ONE)
        else $error("specular base above one");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(tail_valid) && $stable(tail_p))
        else $error("power pipeline moved while held");

endmodule

/* rtl/core/phong_color.sv */
module phong_color #(
    parameter int FRAC_BITS = 15
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               pow_valid,
    input  logic [FRAC_BITS:0] p,
    input  logic [FRAC_BITS+1+phong_pkg::NUM_CH*phong_pkg::NUM_SC*(2*phong_pkg::CH_W-FRAC_BITS)-1:0] side,
    output logic               shade_valid,
    output phong_pkg::color_t  shade
);
    import phong_pkg::*;

    localparam int U_W    = FRAC_BITS + 1;
    localparam int S_W    = 2 * CH_W - FRAC_BITS;
    localparam int SC_W   = NUM_CH * NUM_SC * S_W;
    localparam int SIDE_W = U_W + SC_W;
    localparam int P_W    = S_W + U_W;
    localparam int T_W    = S_W + 2;
    localparam int Y_W    = T_W + COLOR_W;

    logic [U_W-1:0]     ld_in;
    logic [S_W-1:0]     diff_in [NUM_CH];
    logic [S_W-1:0]     spec_in [NUM_CH];
    logic [S_W-1:0]     amb_in  [NUM_CH];
    logic [P_W-1:0]     diff_full [NUM_CH];
    logic [P_W-1:0]     spec_full [NUM_CH];

    logic               c1_valid_reg;
    logic [S_W-1:0]     c1_diff_reg [NUM_CH];
    logic [S_W-1:0]     c1_spec_reg [NUM_CH];
    logic [S_W-1:0]     c1_amb_reg  [NUM_CH];

    logic               c2_valid_reg;
    logic [T_W-1:0]     c2_tot_reg [NUM_CH];

    logic               c3_valid_reg;
    color_t             c3_color_reg;

    logic [Y_W-1:0]     y   [NUM_CH];
    logic [Y_W-1:0]     sh  [NUM_CH];
    logic [COLOR_W-1:0] byte_sat [NUM_CH];
    color_t             color_next;

    always_comb
    begin
        ld_in = side[SIDE_W-1 -: U_W];
        for (int c = 0; c < NUM_CH; c++)
        begin
            diff_in[c]   = side[(c*NUM_SC+SC_DIFF)*S_W +: S_W];
            spec_in[c]   = side[(c*NUM_SC+SC_SPEC)*S_W +: S_W];
            amb_in[c]    = side[(c*NUM_SC+SC_AMB)*S_W +: S_W];
            diff_full[c] = P_W'(diff_in[c]) * P_W'(ld_in);
            spec_full[c] = P_W'(spec_in[c]) * P_W'(p);
        end
    end

    // I * 255 as a shift and subtract, then saturate
    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            y[c]  = (Y_W'(c2_tot_reg[c]) << COLOR_W) - Y_W'(c2_tot_reg[c]);
            sh[c] = y[c] >> FRAC_BITS;
            byte_sat[c] = (sh[c] > Y_W'(COLOR_MAX)) ? COLOR_MAX : sh[c][COLOR_W-1:0];
        end
        color_next.red   = byte_sat[0];
        color_next.green = byte_sat[1];
        color_next.blue  = byte_sat[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_valid_reg <= 1'b0;
            c2_valid_reg <= 1'b0;
            c3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            c1_valid_reg <= pow_valid;
            c2_valid_reg <= c1_valid_reg;
            c3_valid_reg <= c2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < NUM_CH; c++)
            begin
                c1_diff_reg[c] <= S_W'(diff_full[c] >> FRAC_BITS);
                c1_spec_reg[c] <= S_W'(spec_full[c] >> FRAC_BITS);
                c1_amb_reg[c]  <= amb_in[c];
                c2_tot_reg[c]  <= T_W'(c1_diff_reg[c]) + T_W'(c1_spec_reg[c])
                                  + T_W'(c1_amb_reg[c]);
            end
            c3_color_reg <= color_next;
        end
    end

    assign shade_valid = c3_valid_reg;
    assign shade       = c3_color_reg;

endmodule

/* rtl/core/phong_pixel_shader.sv */
// phong_pixel_shader: per-pixel phong shading, one rgb byte triple per pixel
//
// pixel channel: pixel_valid / pixel_stall / pixel. a transfer happens on a
//   clock edge with pixel_valid high and pixel_stall low.
// color channel: color_valid / color_stall / color, same rules; color_valid and
//   color come straight from the last pipeline register.
// config channel: cfg_valid / cfg_ready / cfg_index / cfg_data. cfg_ready is
//   always high; index CFG_LIGHT sets the point light, CFG_AMBIENT the ambient.
//   write only while no pixel is in flight.
// throughput: one pixel per clock, every clock, as long as color_stall is low.
// depth: 9 + 2**min(MAX_SHININESS_BITS, 6) - 1 register stages, 72 at the default
//   parameters. the depth is set by the specular power chain: one fixed-point
//   multiply stage per exponent step.
// stall: while color_valid and color_stall are both high, the whole pipeline
//   holds and pixel_stall is raised; nothing is dropped or repeated.
// reset: rst_n clears every valid bit and both light registers to zero.
module phong_pixel_shader #(
    parameter int FRAC_BITS          = 15,
    parameter int MAX_SHININESS_BITS = 6
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              pixel_valid,
    output logic                              pixel_stall,
    input  phong_pkg::pixel_t                 pixel,
    output logic                              color_valid,
    input  logic                              color_stall,
    output phong_pkg::color_t                 color,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  phong_pkg::cfg_reg_t               cfg_index,
    input  logic [phong_pkg::RGB_W-1:0]       cfg_data
);
    import phong_pkg::*;

    // exponent bits actually used from the shininess field
    localparam int M_W    = (MAX_SHININESS_BITS < SHINE_W) ? MAX_SHININESS_BITS : SHINE_W;
    localparam int U_W    = FRAC_BITS + 1;
    localparam int S_W    = 2 * CH_W - FRAC_BITS;
    localparam int SC_W   = NUM_CH * NUM_SC * S_W;
    localparam int SIDE_W = U_W + SC_W;

    // light registers, three q1.15 channels each, red low
    logic [RGB_W-1:0] light_reg;
    logic [RGB_W-1:0] ambient_reg;

    // global advance: the pipeline moves unless a finished color is held
    logic en;

    // front end outputs
    logic              vec_valid;
    logic [U_W-1:0]    vec_ld;
    logic [U_W-1:0]    vec_rs;
    logic [U_W-1:0]    vec_p0;
    logic [M_W-1:0]    vec_shine;
    logic [SC_W-1:0]   vec_scale;

    // power chain outputs
    logic              pow_valid;
    logic [U_W-1:0]    pow_p;
    logic [SIDE_W-1:0] pow_side;

    assign en          = !(color_valid && color_stall);
    assign pixel_stall = !en;
    assign cfg_ready   = 1'b1;

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            light_reg   <= '0;
            ambient_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_LIGHT:   light_reg   <= cfg_data;
                CFG_AMBIENT: ambient_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    // dot products, reflection, clamps and light scale products
    phong_front #(
        .FRAC_BITS (FRAC_BITS),
        .M_W       (M_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .pix_valid (pixel_valid),
        .pix       (pixel),
        .light     (light_reg),
        .ambient   (ambient_reg),
        .vec_valid (vec_valid),
        .ld        (vec_ld),
        .rs        (vec_rs),
        .p0        (vec_p0),
        .shine     (vec_shine),
        .scale     (vec_scale)
    );

    // specular power, one multiply per stage; diffuse factor and scales ride along
    phong_pow #(
        .FRAC_BITS (FRAC_BITS),
        .M_W       (M_W),
        .SIDE_W    (SIDE_W)
    ) u_pow (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .head_valid (vec_valid),
        .head_rs    (vec_rs),
        .head_p     (vec_p0),
        .head_shine (vec_shine),
        .head_side  ({vec_ld, vec_scale}),
        .tail_valid (pow_valid),
        .tail_p     (pow_p),
        .tail_side  (pow_side)
    );

    // term sum, byte conversion, output register
    phong_color #(
        .FRAC_BITS (FRAC_BITS)
    ) u_color (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .pow_valid   (pow_valid),
        .p           (pow_p),
        .side        (pow_side),
        .shade_valid (color_valid),
        .shade       (color)
    );

endmodule
